### rtl/core/sliding_window_median_size_assert.svh
// ============================================================================
// sliding_window_median_size_assert.svh
// Assertion macros shared by the sliding window median RTL. They compile to
// nothing when SYNTHESIS is defined.
// ============================================================================
`ifndef SLIDING_WINDOW_MEDIAN_SIZE_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_SIZE_ASSERT_SVH

`ifndef SYNTHESIS

// Condition holds at every clock edge out of reset
`define SWMS_ASSERT_INV(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant check failed");

// Antecedent implies consequent in the same cycle
`define SWMS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Antecedent implies consequent in the next cycle
`define SWMS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define SWMS_ASSERT_INV(label, clk, rst_n, cond)
`define SWMS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SWMS_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/core/swms_pkg.sv
// ============================================================================
// swms_pkg
// Shared types and constants for the sliding window median of box sizes.
// ============================================================================
`default_nettype none

package swms_pkg;

    // Default configuration
    localparam int DEFAULT_WINDOW    = 8;
    localparam int DEFAULT_SIZE_BITS = 16;

    // Port field width of a size sample
    localparam int FIELD_BITS = 16;

    // A window needs this many entries before the median is used
    localparam int MIN_FOR_MEDIAN = 3;

    // Request queue between front and back (power of two)
    localparam int QUEUE_DEPTH = 2;

    // Request command codes
    typedef enum logic [0:0] {
        CMD_PUSH  = 1'b0,
        CMD_CLEAR = 1'b1
    } cmd_t;

    // Classified request as held in the queue
    typedef struct packed {
        logic                  clear;
        logic [FIELD_BITS-1:0] width;
        logic [FIELD_BITS-1:0] height;
    } item_t;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH,
        ST_OUT
    } state_t;

    // Sequencer controls to the rank lanes
    typedef struct packed {
        logic push;     // shift a new sample into the history
        logic first;    // the window was empty before this push
        logic scan;     // step the candidate scan
        logic cand_ok;  // current candidate is a stored entry and ranking is on
    } lane_ctl_t;

endpackage

`default_nettype wire

### rtl/core/swms_front.sv
// ============================================================================
// swms_front
// Accepts requests, classifies them as push or clear and queues them for
// the back end.
// ============================================================================
`default_nettype none

`include "sliding_window_median_size_assert.svh"

module swms_front (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               command,
    input  wire logic [swms_pkg::FIELD_BITS-1:0]    box_width,
    input  wire logic [swms_pkg::FIELD_BITS-1:0]    box_height,
    output logic                                    q_valid,
    input  wire logic                               q_ready,
    output swms_pkg::item_t                         q_item
);

    localparam int PtrW = (swms_pkg::QUEUE_DEPTH > 1) ? $clog2(swms_pkg::QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(swms_pkg::QUEUE_DEPTH + 1);

    swms_pkg::item_t   entry_reg [swms_pkg::QUEUE_DEPTH];
    logic [PtrW-1:0]   wr_ptr_reg;
    logic [PtrW-1:0]   wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg;
    logic [PtrW-1:0]   rd_ptr_next;
    logic [CntW-1:0]   count_reg;
    logic [CntW-1:0]   count_next;
    logic              push;
    logic              pop;
    swms_pkg::item_t   item_in;

    // Classify the incoming request
    always_comb
    begin
        item_in.clear  = (command == swms_pkg::CMD_CLEAR);
        item_in.width  = box_width;
        item_in.height = box_height;
    end

    // Handshakes
    assign in_ready = (count_reg != CntW'(swms_pkg::QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_valid && q_ready;
    assign q_item   = entry_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + PtrW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + PtrW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CntW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= item_in;
        end
    end

    // Checks
    `SWMS_ASSERT_NXT(a_fill_grows, clk, rst_n, push && !pop, count_reg == $past(count_reg) + CntW'(1))
    `SWMS_ASSERT_NXT(a_drain_shrinks, clk, rst_n, pop && !push, count_reg == $past(count_reg) - CntW'(1))

endmodule

`default_nettype wire

### rtl/core/swms_rank.sv
// ============================================================================
// swms_rank
// One history window with its rank selector. Entries sit in a shift line,
// newest first; a copy shifts one candidate per cycle past a bank of
// comparators, and a registered count stage picks the entry of rank n/2.
// ============================================================================
`default_nettype none

module swms_rank #(
    parameter int WINDOW    = swms_pkg::DEFAULT_WINDOW,
    parameter int SIZE_BITS = swms_pkg::DEFAULT_SIZE_BITS
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire swms_pkg::lane_ctl_t              ctl,
    input  wire logic [$clog2(WINDOW+1)-1:0]      fill,
    input  wire logic [SIZE_BITS-1:0]             sample,
    output logic      [SIZE_BITS-1:0]             result
);

    localparam int CntW = $clog2(WINDOW + 1);

    logic [SIZE_BITS-1:0] hist_reg [WINDOW];
    logic [SIZE_BITS-1:0] scan_reg [WINDOW];
    logic [SIZE_BITS-1:0] cand_reg;
    logic [SIZE_BITS-1:0] result_reg;
    logic [WINDOW-1:0]    lt_reg;
    logic [WINDOW-1:0]    le_reg;
    logic [WINDOW-1:0]    lt_next;
    logic [WINDOW-1:0]    le_next;
    logic                 ok_reg;
    logic [CntW-1:0]      below;
    logic [CntW-1:0]      at_or_below;
    logic [CntW-1:0]      rank;
    logic                 hit;

    // Compare stage: current candidate against every stored entry
    always_comb
    begin
        for (int j = 0; j < WINDOW; j++)
        begin
            lt_next[j] = (CntW'(j) < fill) && (hist_reg[j] <  scan_reg[0]);
            le_next[j] = (CntW'(j) < fill) && (hist_reg[j] <= scan_reg[0]);
        end
    end

    // Count stage: the candidate whose rank range covers n/2 is the median
    always_comb
    begin
        below       = '0;
        at_or_below = '0;
        for (int j = 0; j < WINDOW; j++)
        begin
            below       = below + CntW'(lt_reg[j]);
            at_or_below = at_or_below + CntW'(le_reg[j]);
        end
        rank = fill >> 1;
        hit  = ok_reg && (below <= rank) && (rank < at_or_below);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_reg <= 1'b0;
        end
        else
        begin
            ok_reg <= ctl.cand_ok;
        end
    end

    // History shift line, candidate rotation and result
    always_ff @(posedge clk)
    begin
        lt_reg   <= lt_next;
        le_reg   <= le_next;
        cand_reg <= scan_reg[0];
        if (ctl.push)
        begin
            hist_reg[0] <= sample;
            scan_reg[0] <= sample;
            for (int i = 1; i < WINDOW; i++)
            begin
                hist_reg[i] <= hist_reg[i-1];
                scan_reg[i] <= hist_reg[i-1];
            end
            // short window: oldest entry is the new sample or the previous one
            result_reg <= ctl.first ? sample : hist_reg[0];
        end
        else
        begin
            if (ctl.scan)
            begin
                for (int i = 0; i < WINDOW - 1; i++)
                begin
                    scan_reg[i] <= scan_reg[i+1];
                end
            end
            if (hit)
            begin
                result_reg <= cand_reg;
            end
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

### rtl/core/swms_back.sv
// ============================================================================
// swms_back
// Sequencer that takes queued requests, updates both histories, runs the
// rank scan on the width and height lanes and holds the result.
// ============================================================================
`default_nettype none

`include "sliding_window_median_size_assert.svh"

module swms_back #(
    parameter int WINDOW    = swms_pkg::DEFAULT_WINDOW,
    parameter int SIZE_BITS = swms_pkg::DEFAULT_SIZE_BITS
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               q_valid,
    output logic                                    q_ready,
    input  wire swms_pkg::item_t                    q_item,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [swms_pkg::FIELD_BITS-1:0]         median_width,
    output logic [swms_pkg::FIELD_BITS-1:0]         median_height
);

    localparam int CntW = $clog2(WINDOW + 1);

    swms_pkg::state_t     state_reg;
    swms_pkg::state_t     state_next;
    logic [CntW-1:0]      fill_reg;
    logic [CntW-1:0]      fill_next;
    logic [CntW-1:0]      idx_reg;
    logic [CntW-1:0]      idx_next;
    swms_pkg::lane_ctl_t  ctl;
    logic                 ranked;
    logic [SIZE_BITS-1:0] res_w;
    logic [SIZE_BITS-1:0] res_h;

    // Median is used once the window holds enough entries
    assign ranked = ({{(32-CntW){1'b0}}, fill_reg} >= 32'(swms_pkg::MIN_FOR_MEDIAN));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            swms_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_item.clear)
                    begin
                        fill_next = '0;
                    end
                    else
                    begin
                        if (fill_reg != CntW'(WINDOW))
                        begin
                            fill_next = fill_reg + CntW'(1);
                        end
                        idx_next   = '0;
                        state_next = swms_pkg::ST_SCAN;
                    end
                end
            end
            swms_pkg::ST_SCAN:
            begin
                idx_next = idx_reg + CntW'(1);
                if (idx_reg == CntW'(WINDOW - 1))
                begin
                    state_next = swms_pkg::ST_FINISH;
                end
            end
            swms_pkg::ST_FINISH:
            begin
                state_next = swms_pkg::ST_OUT;
            end
            swms_pkg::ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = swms_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swms_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and lane controls
    always_comb
    begin
        q_ready     = 1'b0;
        out_valid   = 1'b0;
        ctl.push    = 1'b0;
        ctl.first   = 1'b0;
        ctl.scan    = 1'b0;
        ctl.cand_ok = 1'b0;
        unique case (state_reg)
            swms_pkg::ST_IDLE:
            begin
                q_ready   = 1'b1;
                ctl.push  = q_valid && !q_item.clear;
                ctl.first = (fill_reg == '0);
            end
            swms_pkg::ST_SCAN:
            begin
                ctl.scan    = 1'b1;
                ctl.cand_ok = ranked && (idx_reg < fill_reg);
            end
            swms_pkg::ST_FINISH:
            begin
                ctl.scan = 1'b0;
            end
            swms_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                q_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= swms_pkg::ST_IDLE;
            fill_reg  <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            idx_reg   <= idx_next;
        end
    end

    // Width and height lanes
    swms_rank #(
        .WINDOW    (WINDOW),
        .SIZE_BITS (SIZE_BITS)
    ) u_rank_w (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .fill   (fill_reg),
        .sample (SIZE_BITS'(q_item.width)),
        .result (res_w)
    );

    swms_rank #(
        .WINDOW    (WINDOW),
        .SIZE_BITS (SIZE_BITS)
    ) u_rank_h (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .fill   (fill_reg),
        .sample (SIZE_BITS'(q_item.height)),
        .result (res_h)
    );

    assign median_width  = swms_pkg::FIELD_BITS'(res_w);
    assign median_height = swms_pkg::FIELD_BITS'(res_h);

    // Checks
    `SWMS_ASSERT_INV(a_fill_bound, clk, rst_n, fill_reg <= CntW'(WINDOW))
    `SWMS_ASSERT_NXT(a_clear_empties, clk, rst_n, q_valid && q_ready && q_item.clear, fill_reg == '0)
    `SWMS_ASSERT_NXT(a_push_scans, clk, rst_n, ctl.push, (state_reg == swms_pkg::ST_SCAN) && (fill_reg != '0))
    `SWMS_ASSERT_NXT(a_finish_shows, clk, rst_n, state_reg == swms_pkg::ST_FINISH, out_valid)

endmodule

`default_nettype wire

### rtl/core/sliding_window_median_size.sv
// ============================================================================
// sliding_window_median_size
// Sliding window median of tracked box widths and heights.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready): command 0 pushes box_width and
//   box_height into the two histories and yields one result; command 1
//   clears both histories and yields nothing.
//   Output channel (out_valid/out_ready): median_width and median_height,
//   the entry of rank n/2 of each window (upper median for even n), or the
//   oldest entry while a window holds fewer than three samples.
//   A push taken from the queue passes the scan and finish states before
//   out_valid rises in the output state. The back end takes no new request
//   until out_ready takes the result; a clear is handled in the idle state
//   without a scan. The candidate scan walks one stored entry per cycle past
//   the comparator bank, followed by one count stage.
//   A two-entry request queue keeps accepting while a result waits; when the
//   receiver stalls the result holds and the queue fills, then in_ready drops.
//   Reset empties the queue and both histories; no result is pending.
// ============================================================================
`default_nettype none

module sliding_window_median_size #(
    parameter int WINDOW    = swms_pkg::DEFAULT_WINDOW,
    parameter int SIZE_BITS = swms_pkg::DEFAULT_SIZE_BITS
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               command,
    input  wire logic [swms_pkg::FIELD_BITS-1:0]    box_width,
    input  wire logic [swms_pkg::FIELD_BITS-1:0]    box_height,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [swms_pkg::FIELD_BITS-1:0]         median_width,
    output logic [swms_pkg::FIELD_BITS-1:0]         median_height
);

    logic            q_valid;
    logic            q_ready;
    swms_pkg::item_t q_item;

    // Request intake and queue
    swms_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .box_width  (box_width),
        .box_height (box_height),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_item     (q_item)
    );

    // History update, rank selection and result register
    swms_back #(
        .WINDOW    (WINDOW),
        .SIZE_BITS (SIZE_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .median_width  (median_width),
        .median_height (median_height)
    );

endmodule

`default_nettype wire
